>>> hdl/connection_slot_send_manager_assert.svh
`ifndef CONNECTION_SLOT_SEND_MANAGER_ASSERT_SVH
`define CONNECTION_SLOT_SEND_MANAGER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csm: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csm: next-cycle check failed");

`endif

>>> hdl/csm_pkg.sv
`timescale 1ns / 1ps

package csm_pkg;

    localparam int SLOT_COUNT_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int MAX_FRAME_DEF   = 1024;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;
    localparam int OP_W        = 3;
    localparam int KIND_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // event codes
    localparam logic [OP_W-1:0] OP_CONNECT    = 3'd0;
    localparam logic [OP_W-1:0] OP_SEND       = 3'd1;
    localparam logic [OP_W-1:0] OP_CONFIRM    = 3'd2;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd3;
    localparam logic [OP_W-1:0] OP_CHUNK      = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPTED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CONNECTED    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSED      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TX_PAYLOAD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR_MSG      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FRAME_DONE   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLOSE_REQ    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_DISCONNECTED = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_BAD_START_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LEN  = 2'd1;
    localparam logic [CFG_DATA_W-1:0] MSG_LEN_RST      = 8'd32;

    localparam logic [15:0] ERR_BAD_START = 16'd0;
    localparam logic [15:0] ERR_OVERFLOW  = 16'd1;

    localparam logic [7:0] OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;

    typedef struct packed {
        logic               load_in;
        logic               srch_init;
        logic               srch_step;
        logic               srch_take;
        logic               srch_fail;
        logic               enq;
        logic               enq_code;
        logic               take;
        logic               pop;
        logic               free_s;
        logic               held_wr;
        logic               emit;
        logic [KIND_W-1:0]  emit_kind;
        logic               flush;
    } t_ctl_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            slot_ok;
        logic            slot_free;
        logic            len_zero;
        logic            held_zero;
        logic            fb_open;
        logic            lb_close;
        logic            over;
        logic            srch_free;
        logic            srch_end;
        logic            q_full;
        logic            q_empty;
        logic            outstanding;
        logic            head_free;
        logic            stg_vld;
        logic            out_free;
    } t_ctl_stat;

endpackage

>>> hdl/csm_ctrl.sv
`timescale 1ns / 1ps

module csm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  csm_pkg::t_ctl_stat   i_stat,
    output csm_pkg::t_ctl_cmd    o_cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DECODE    = 4'd1;
    localparam logic [3:0] ST_SEARCH    = 4'd2;
    localparam logic [3:0] ST_SN_RD     = 4'd3;
    localparam logic [3:0] ST_SN_CHK    = 4'd4;
    localparam logic [3:0] ST_RET       = 4'd5;
    localparam logic [3:0] ST_DISC_CHK  = 4'd6;
    localparam logic [3:0] ST_CHUNK_CHK = 4'd7;
    localparam logic [3:0] ST_FLUSH     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_emit_ok;

    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n;
    // a new result may enter the stage once the staged one can move on
    assign w_emit_ok  = !i_stat.stg_vld || i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.op)
                    csm_pkg::OP_CONNECT: begin
                        o_cmd.srch_init = 1'b1;
                        n_state         = ST_SEARCH;
                    end
                    csm_pkg::OP_SEND: begin
                        if (!i_stat.slot_ok) begin
                            n_state = ST_FLUSH;
                        end else if (i_stat.q_full) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = csm_pkg::KIND_REFUSED;
                            n_state         = ST_FLUSH;
                        end else begin
                            o_cmd.enq       = 1'b1;
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = csm_pkg::KIND_ACCEPTED;
                            n_state         = ST_SN_RD;
                        end
                    end
                    csm_pkg::OP_CONFIRM: begin
                        o_cmd.pop = 1'b1;
                        n_state   = ST_SN_RD;
                    end
                    csm_pkg::OP_DISCONNECT: begin
                        if (!i_stat.slot_ok) begin
                            n_state = ST_FLUSH;
                        end else begin
                            o_cmd.free_s = 1'b1;
                            n_state      = ST_DISC_CHK;
                        end
                    end
                    csm_pkg::OP_CHUNK: begin
                        if (!i_stat.slot_ok || i_stat.slot_free || i_stat.len_zero) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_state = ST_CHUNK_CHK;
                        end
                    end
                    default: begin
                        n_state = ST_FLUSH;
                    end
                endcase
            end
            ST_SEARCH: begin
                if (i_stat.srch_free) begin
                    o_cmd.srch_take = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = csm_pkg::KIND_CONNECTED;
                    n_state         = ST_FLUSH;
                end else if (i_stat.srch_end) begin
                    o_cmd.srch_fail = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = csm_pkg::KIND_REFUSED;
                    n_state         = ST_FLUSH;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            ST_SN_RD: begin
                if (i_stat.outstanding || i_stat.q_empty) begin
                    n_state = ST_RET;
                end else begin
                    n_state = ST_SN_CHK;
                end
            end
            ST_SN_CHK: begin
                // drop a head entry whose slot has closed, else transmit it
                if (i_stat.head_free) begin
                    o_cmd.take = 1'b1;
                    o_cmd.pop  = 1'b1;
                    n_state    = ST_SN_RD;
                end else if (w_emit_ok) begin
                    o_cmd.take      = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = csm_pkg::KIND_TX_PAYLOAD;
                    n_state         = ST_RET;
                end
            end
            ST_RET: begin
                if (i_stat.op == csm_pkg::OP_DISCONNECT) begin
                    if (w_emit_ok) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = csm_pkg::KIND_DISCONNECTED;
                        n_state         = ST_FLUSH;
                    end
                end else if (i_stat.op == csm_pkg::OP_CHUNK) begin
                    if (w_emit_ok) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = csm_pkg::KIND_CLOSE_REQ;
                        n_state         = ST_FLUSH;
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_DISC_CHK: begin
                if (i_stat.outstanding && !i_stat.q_empty && i_stat.head_free) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_SN_RD;
                end else begin
                    n_state = ST_RET;
                end
            end
            ST_CHUNK_CHK: begin
                if (i_stat.held_zero && !i_stat.fb_open) begin
                    if (!i_stat.q_full) begin
                        o_cmd.enq = 1'b1;
                        n_state   = ST_SN_RD;
                    end else begin
                        n_state = ST_RET;
                    end
                end else if (i_stat.over) begin
                    if (!i_stat.q_full) begin
                        o_cmd.enq      = 1'b1;
                        o_cmd.enq_code = 1'b1;
                        n_state        = ST_SN_RD;
                    end else begin
                        n_state = ST_RET;
                    end
                end else begin
                    o_cmd.held_wr   = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = i_stat.lb_close ? csm_pkg::KIND_FRAME_DONE
                                                      : csm_pkg::KIND_ACCEPTED;
                    n_state         = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_stat.stg_vld) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/csm_dpath.sv
`timescale 1ns / 1ps

module csm_dpath #(
    parameter int SLOT_COUNT  = csm_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = csm_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_FRAME   = csm_pkg::MAX_FRAME_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  csm_pkg::t_ctl_cmd                  i_cmd,
    output csm_pkg::t_ctl_stat                 o_stat,
    input  logic [csm_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic [csm_pkg::OP_W-1:0]           i_in_op,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [csm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [csm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [csm_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic [csm_pkg::KIND_W-1:0]         o_out_kind,
    output logic                               o_out_last
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int HW = $clog2(MAX_FRAME + 1);
    localparam int EW = SW + 33;

    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);
    localparam logic [6:0]    SLOT_LIM  = 7'(SLOT_COUNT);
    localparam logic [QW:0]   Q_DEPTH   = (QW + 1)'(QUEUE_DEPTH);
    localparam logic [QW-1:0] Q_LAST    = QW'(QUEUE_DEPTH - 1);
    localparam logic [16:0]   FRAME_MAX = 17'(MAX_FRAME);

    // latched event
    logic [csm_pkg::OP_W-1:0] r_op;
    logic [2:0]               r_slot;
    logic [15:0]              r_handle;
    logic [15:0]              r_len;
    logic [7:0]               r_fb;
    logic [7:0]               r_lb;

    logic [csm_pkg::CFG_DATA_W-1:0] r_bad_len;
    logic [csm_pkg::CFG_DATA_W-1:0] r_ovf_len;

    logic [SLOT_COUNT-1:0] r_free;
    logic [SLOT_COUNT-1:0] r_hvld;
    logic [HW-1:0]         m_held [SLOT_COUNT];
    logic [HW-1:0]         r_held_rd;

    logic [SW-1:0] r_sstart;
    logic [SW-1:0] r_sptr;
    logic [SW-1:0] r_scnt;

    logic [EW-1:0] m_q [QUEUE_DEPTH];
    logic [EW-1:0] r_q_rd;
    logic [QW-1:0] r_qhead;
    logic [QW:0]   r_qcnt;
    logic          r_outst;

    logic [csm_pkg::KIND_W-1:0] r_stg_kind;
    logic [2:0]                 r_stg_slot;
    logic [15:0]                r_stg_handle;
    logic [15:0]                r_stg_len;
    logic                       r_stg_vld;

    logic                       r_out_vld;
    logic [csm_pkg::KIND_W-1:0] r_out_kind;
    logic [2:0]                 r_out_slot;
    logic [15:0]                r_out_handle;
    logic [15:0]                r_out_len;
    logic                       r_out_last;

    logic [6:0]    w_slot_ext;
    logic [SW-1:0] w_sidx;
    logic [SW-1:0] w_sptr_nxt;
    logic [6:0]    w_sptr_ext;
    logic [SW-1:0] w_e_slot;
    logic [6:0]    w_e_slot_ext;
    logic [15:0]   w_e_handle;
    logic [15:0]   w_e_len;
    logic          w_e_err;
    logic [HW-1:0] w_held;
    logic [16:0]   w_sum;
    logic [QW:0]   w_tsum;
    logic [QW:0]   w_tsum_wrap;
    logic [QW-1:0] w_tail;
    logic          w_enq_err;
    logic [15:0]   w_enq_handle;
    logic [15:0]   w_enq_len;
    logic [EW-1:0] w_enq_data;
    logic          w_pop;
    logic          w_to_out;

    logic [csm_pkg::KIND_W-1:0] w_kind;
    logic [2:0]                 w_res_slot;
    logic [15:0]                w_res_handle;
    logic [15:0]                w_res_len;

    assign w_slot_ext   = {4'b0000, r_slot};
    assign w_sidx       = w_slot_ext[SW-1:0];
    assign w_sptr_nxt   = (r_sptr == SLOT_LAST) ? '0 : r_sptr + 1'b1;
    assign w_sptr_ext   = 7'(r_sptr);

    assign w_e_slot     = r_q_rd[SW-1:0];
    assign w_e_slot_ext = 7'(w_e_slot);
    assign w_e_handle   = r_q_rd[SW+15:SW];
    assign w_e_len      = r_q_rd[SW+31:SW+16];
    assign w_e_err      = r_q_rd[SW+32];

    assign w_held = r_hvld[w_sidx] ? r_held_rd : '0;
    assign w_sum  = 17'(w_held) + {1'b0, r_len};

    assign w_tsum      = {1'b0, r_qhead} + r_qcnt;
    assign w_tsum_wrap = w_tsum - Q_DEPTH;
    assign w_tail      = (w_tsum >= Q_DEPTH) ? w_tsum_wrap[QW-1:0] : w_tsum[QW-1:0];

    // error messages come from chunk events, payload sends from send requests
    assign w_enq_err    = (r_op == csm_pkg::OP_CHUNK);
    assign w_enq_handle = !w_enq_err ? r_handle
                        : (i_cmd.enq_code ? csm_pkg::ERR_OVERFLOW : csm_pkg::ERR_BAD_START);
    assign w_enq_len    = !w_enq_err ? r_len
                        : {8'h00, (i_cmd.enq_code ? r_ovf_len : r_bad_len)};
    assign w_enq_data   = {w_enq_err, w_enq_len, w_enq_handle, w_sidx};

    assign w_pop = i_cmd.pop && (r_outst || i_cmd.take) && (r_qcnt != '0);

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_in_op;
            r_slot   <= i_in_data[2:0];
            r_handle <= i_in_data[18:3];
            r_len    <= i_in_data[34:19];
            r_fb     <= i_in_data[42:35];
            r_lb     <= i_in_data[50:43];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_len <= csm_pkg::MSG_LEN_RST;
            r_ovf_len <= csm_pkg::MSG_LEN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == csm_pkg::CFG_BAD_START_LEN) begin
                r_bad_len <= i_cfg_data;
            end else if (i_cfg_index == csm_pkg::CFG_OVERFLOW_LEN) begin
                r_ovf_len <= i_cfg_data;
            end
        end
    end

    // slot table and search pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= '1;
            r_hvld   <= '0;
            r_sstart <= '0;
            r_sptr   <= '0;
            r_scnt   <= '0;
        end else begin
            if (i_cmd.srch_init) begin
                r_sptr <= r_sstart;
                r_scnt <= '0;
            end
            if (i_cmd.srch_step) begin
                r_sptr <= w_sptr_nxt;
                r_scnt <= r_scnt + 1'b1;
            end
            if (i_cmd.srch_take) begin
                r_free[r_sptr] <= 1'b0;
                r_hvld[r_sptr] <= 1'b0;
                r_sstart       <= w_sptr_nxt;
            end
            if (i_cmd.srch_fail) begin
                r_sstart <= '0;
            end
            if (i_cmd.free_s) begin
                r_free[w_sidx] <= 1'b1;
                r_hvld[w_sidx] <= 1'b0;
            end
            if (i_cmd.held_wr) begin
                r_hvld[w_sidx] <= !(r_lb == csm_pkg::CLOSE_BRACE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_rd <= m_held[w_sidx];
        if (i_cmd.held_wr) begin
            m_held[w_sidx] <= w_sum[HW-1:0];
        end
    end

    // send queue
    always_ff @(posedge i_clk) begin
        r_q_rd <= m_q[r_qhead];
        if (i_cmd.enq) begin
            m_q[w_tail] <= w_enq_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qhead <= '0;
            r_qcnt  <= '0;
            r_outst <= 1'b0;
        end else begin
            if (w_pop) begin
                r_qhead <= (r_qhead == Q_LAST) ? '0 : r_qhead + 1'b1;
                r_qcnt  <= r_qcnt - 1'b1;
                r_outst <= 1'b0;
            end else begin
                if (i_cmd.take) begin
                    r_outst <= 1'b1;
                end
                if (i_cmd.enq) begin
                    r_qcnt <= r_qcnt + 1'b1;
                end
            end
        end
    end

    // result selection
    always_comb begin
        w_kind       = i_cmd.emit_kind;
        w_res_slot   = r_slot;
        w_res_handle = '0;
        w_res_len    = '0;
        case (i_cmd.emit_kind)
            csm_pkg::KIND_CONNECTED: begin
                w_res_slot = w_sptr_ext[2:0];
            end
            csm_pkg::KIND_REFUSED: begin
                w_res_slot = (r_op == csm_pkg::OP_CONNECT) ? 3'd0 : r_slot;
            end
            csm_pkg::KIND_TX_PAYLOAD: begin
                w_kind       = w_e_err ? csm_pkg::KIND_ERR_MSG : csm_pkg::KIND_TX_PAYLOAD;
                w_res_slot   = w_e_slot_ext[2:0];
                w_res_handle = w_e_handle;
                w_res_len    = w_e_len;
            end
            csm_pkg::KIND_ACCEPTED: begin
                if (r_op == csm_pkg::OP_SEND) begin
                    w_res_handle = r_handle;
                    w_res_len    = r_len;
                end else begin
                    w_res_len = w_sum[15:0];
                end
            end
            csm_pkg::KIND_FRAME_DONE: begin
                w_res_len = w_sum[15:0];
            end
            default: begin
                w_res_slot = r_slot;
            end
        endcase
    end

    // one staged result, so the final one can be marked last
    assign w_to_out = i_cmd.flush || (i_cmd.emit && r_stg_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_to_out) begin
                r_out_vld <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_stg_vld <= 1'b0;
            end else if (i_cmd.emit) begin
                r_stg_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_to_out) begin
            r_out_kind   <= r_stg_kind;
            r_out_slot   <= r_stg_slot;
            r_out_handle <= r_stg_handle;
            r_out_len    <= r_stg_len;
            r_out_last   <= i_cmd.flush;
        end
        if (i_cmd.emit) begin
            r_stg_kind   <= w_kind;
            r_stg_slot   <= w_res_slot;
            r_stg_handle <= w_res_handle;
            r_stg_len    <= w_res_len;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {5'b00000, r_out_len, r_out_handle, r_out_slot};

    assign o_stat.op          = r_op;
    assign o_stat.slot_ok     = (w_slot_ext < SLOT_LIM);
    assign o_stat.slot_free   = r_free[w_sidx];
    assign o_stat.len_zero    = (r_len == '0);
    assign o_stat.held_zero   = (w_held == '0);
    assign o_stat.fb_open     = (r_fb == csm_pkg::OPEN_BRACE);
    assign o_stat.lb_close    = (r_lb == csm_pkg::CLOSE_BRACE);
    assign o_stat.over        = (w_sum > FRAME_MAX);
    assign o_stat.srch_free   = r_free[r_sptr];
    assign o_stat.srch_end    = (r_scnt == SLOT_LAST);
    assign o_stat.q_full      = (r_qcnt == Q_DEPTH);
    assign o_stat.q_empty     = (r_qcnt == '0);
    assign o_stat.outstanding = r_outst;
    assign o_stat.head_free   = r_free[w_e_slot];
    assign o_stat.stg_vld     = r_stg_vld;
    assign o_stat.out_free    = !r_out_vld || i_out_ready;

endmodule

>>> hdl/connection_slot_send_manager.sv
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// s_axis    in         tuser: opcode; tdata: slot, data_handle, length, first_byte, final_byte
// m_axis    out        tuser: kind; tdata: out_slot, out_handle, out_length; tlast: last
// cfg       in         index 0 bad_start_msg_len, index 1 overflow_msg_len
//
// One event at a time: the controller walks each event through a few states.
// Connect probes up to SLOT_COUNT slots (one slot probed per cycle); send, confirm,
// disconnect and chunk walk the send queue, and each dropped queue entry costs a further
// registered read of the send queue memory.
// A result waits in a stage and an output register; a stalled m_axis holds only an event
// that must place a new result. i_rst_n is synchronous, active low; no clearing pass follows.

module connection_slot_send_manager #(
    parameter int SLOT_COUNT  = csm_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = csm_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_FRAME   = csm_pkg::MAX_FRAME_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] slot, [18:3] data_handle, [34:19] length, [42:35] first_byte,
    // [50:43] final_byte, [55:51] zero
    input  logic [csm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] opcode
    input  logic [csm_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] out_slot, [18:3] out_handle, [34:19] out_length, [39:35] zero
    output logic [csm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [2:0] kind
    output logic [csm_pkg::KIND_W-1:0]         m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [csm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [csm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    csm_pkg::t_ctl_cmd  w_cmd;
    csm_pkg::t_ctl_stat w_stat;

    csm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    csm_dpath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_FRAME   (MAX_FRAME)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

>>> hdl/csm_checker.sv
`timescale 1ns / 1ps
`include "connection_slot_send_manager_assert.svh"

module csm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [csm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [csm_pkg::KIND_W-1:0]      m_axis_tuser,
    input logic                            m_axis_tlast
);

    // a stalled result beat holds
    `CSM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // an accepted event keeps the input closed for at least the next cycle
    `CSM_ASSERT_NXT(a_one_event, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // these kinds always close their event
    `CSM_ASSERT_IMP(a_single_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == csm_pkg::KIND_CONNECTED || m_axis_tuser == csm_pkg::KIND_REFUSED || m_axis_tuser == csm_pkg::KIND_FRAME_DONE || m_axis_tuser == csm_pkg::KIND_CLOSE_REQ || m_axis_tuser == csm_pkg::KIND_DISCONNECTED), m_axis_tlast)

    // error messages carry code bad start or too much data only
    `CSM_ASSERT_IMP(a_err_code, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == csm_pkg::KIND_ERR_MSG), m_axis_tdata[18:4] == '0)

endmodule

bind connection_slot_send_manager csm_checker u_csm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
